### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/mhrm_pkg.sv
`default_nettype none
package mhrm_pkg;

  localparam int KEY_W         = 32;
  localparam int CAP_W         = 7;
  localparam int DEPTH_DEFAULT = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] removed_key;
    logic             key_valid;
    status_t          status;
  } out_item_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage
`default_nettype wire

### hdl/mhrm_cell.sv
`default_nettype none
// One slot of the sorted row: largest key sits in cell 0.
module mhrm_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  wire logic                      clk,
  input  wire mhrm_pkg::cell_ctl_t       ctl,
  input  wire logic [mhrm_pkg::KEY_W-1:0] ins_key,
  input  wire logic [CNT_W-1:0]          count,
  input  wire logic [mhrm_pkg::KEY_W-1:0] up_key,
  input  wire logic                      up_lt,
  input  wire logic [mhrm_pkg::KEY_W-1:0] down_key,
  output logic      [mhrm_pkg::KEY_W-1:0] key,
  output logic                           lt
);

  logic used;

  // Slot is past the end, or the new key belongs ahead of it.
  assign used = CNT_W'(INDEX) < count;
  assign lt   = !used || (key < ins_key);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (up_lt) begin
        key <= up_key;
      end else if (lt) begin
        key <= ins_key;
      end
    end else if (ctl.rem) begin
      key <= down_key;
    end
  end

endmodule
`default_nettype wire

### hdl/min_heap_remove_max.sv
// min_heap_remove_max: bounded priority queue of unsigned 32-bit keys that
// hands back the largest key on a remove.
// Input channel in_valid/in_ready/in_data carries one item: cmd selects insert
// or remove, key is the value to insert (ignored on remove).
// Output channel out_valid/out_ready/out_data returns exactly one item per
// input item: removed_key and key_valid on a good remove, status OK, FULL
// (insert dropped, contents unchanged) or EMPTY (remove on no entries).
// cfg_we/cfg_wdata write the capacity in any cycle outside reset, with no
// wait; 0 acts as 1, values above DEPTH act as DEPTH.
// Keys live in a row of DEPTH cells kept sorted largest first. Each cell
// compares the broadcast key with its own and takes its neighbor's key, the
// new key, or holds, so one operation is one compare-and-shift step.
// Result: registered, and valid the cycle after acceptance.
// Throughput: one item per cycle while the output is not stalled, set by
// the single compare-and-shift step of the cell row; the output register
// lets a new item in while the last result is being taken.
// Stall: while out_valid is high and out_ready low, in_ready drops and both
// the queue contents and the result hold.
// Reset: entry count cleared, capacity set to 64, output empty. Cell contents
// are not cleared and are never read before being written.
`default_nettype none
`include "assert_macros.svh"
module min_heap_remove_max #(
  parameter int DEPTH = mhrm_pkg::DEPTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire mhrm_pkg::in_item_t        in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output mhrm_pkg::out_item_t            out_data,
  input  wire logic                      cfg_we,
  input  wire logic [mhrm_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = (CNT_W > mhrm_pkg::CAP_W) ? CNT_W : mhrm_pkg::CAP_W;

  logic [CNT_W-1:0]           count, count_next;
  logic [mhrm_pkg::CAP_W-1:0] capacity;
  logic [WIDE_W-1:0]          cap_wide, cap_eff;
  logic                       full, empty, accept;
  mhrm_pkg::cell_ctl_t        ctl;
  mhrm_pkg::out_item_t        out_next;

  logic [mhrm_pkg::KEY_W-1:0] cell_key [DEPTH];
  logic                       cell_lt  [DEPTH];

  // Clamp the programmed capacity into 1..DEPTH.
  always_comb begin
    cap_wide = WIDE_W'(capacity);
    if (capacity == '0) begin
      cap_eff = WIDE_W'(1);
    end else if (cap_wide > WIDE_W'(DEPTH)) begin
      cap_eff = WIDE_W'(DEPTH);
    end else begin
      cap_eff = cap_wide;
    end
  end

  assign full     = WIDE_W'(count) >= cap_eff;
  assign empty    = count == '0;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign ctl.ins = accept && (in_data.cmd == mhrm_pkg::CMD_INSERT) && !full;
  assign ctl.rem = accept && (in_data.cmd == mhrm_pkg::CMD_REMOVE) && !empty;

  // Cell row: each cell sees its upper and lower neighbor.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [mhrm_pkg::KEY_W-1:0] up_key, down_key;
    logic                       up_lt;

    if (gi == 0) begin : g_top
      assign up_key = '0;
      assign up_lt  = 1'b0;
    end else begin : g_mid
      assign up_key = cell_key[gi-1];
      assign up_lt  = cell_lt[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_bot
      assign down_key = cell_key[gi];
    end else begin : g_inner
      assign down_key = cell_key[gi+1];
    end

    mhrm_cell #(
      .CNT_W (CNT_W),
      .INDEX (gi)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .ins_key  (in_data.key),
      .count    (count),
      .up_key   (up_key),
      .up_lt    (up_lt),
      .down_key (down_key),
      .key      (cell_key[gi]),
      .lt       (cell_lt[gi])
    );
  end

  // Advance the entry count on a good insert or remove.
  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Build the result of the item being accepted.
  always_comb begin
    out_next.removed_key = ctl.rem ? cell_key[0] : '0;
    out_next.key_valid   = ctl.rem;
    out_next.status      = mhrm_pkg::STATUS_OK;
    if ((in_data.cmd == mhrm_pkg::CMD_INSERT) && full) begin
      out_next.status = mhrm_pkg::STATUS_FULL;
    end else if ((in_data.cmd == mhrm_pkg::CMD_REMOVE) && empty) begin
      out_next.status = mhrm_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= mhrm_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_next;
    end
  end

  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_IMPL(a_valid_ok, clk, rst, out_valid && out_data.key_valid, out_data.status == mhrm_pkg::STATUS_OK)
  `ASSERT_NEXT(a_ins_count, clk, rst, ctl.ins, count == $past(count) + CNT_W'(1))
  `ASSERT_NEXT(a_rem_max, clk, rst, ctl.rem, out_valid && out_data.removed_key == $past(cell_key[0]))

endmodule
`default_nettype wire
